// ----- hw/rtl/mws_pkg.sv -----
package mws_pkg;

  // Fixed widths of the register file and of the result.
  localparam int CFG_W     = 11;
  localparam int K_W       = 5;
  localparam int ROW_W     = 10;
  localparam int ROW_LIMIT = 1024;
  localparam int OUT_W     = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

  // Position flags that travel with each sample down the pipeline.
  typedef struct packed {
    logic usable;
    logic first_row;
    logic sub_row;
    logic vert_ok;
    logic first_col;
    logic sub_col;
    logic win_ok;
    logic last;
  } mws_tag_t;

endpackage

// ----- hw/rtl/mws_cell.sv -----
module mws_cell #(
  parameter int DATA_W = 21
) (
  input  logic                     clk,
  input  logic                     shift,
  input  logic signed [DATA_W-1:0] d,
  output logic signed [DATA_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ----- hw/rtl/mws_vsum.sv -----
module mws_vsum #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_WINDOW  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  advance,
  input  logic                                  take,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  input  logic [$clog2(MAX_WIDTH)-1:0]          col,
  input  logic [$clog2(MAX_WINDOW)-1:0]         slot,
  input  logic [$clog2(MAX_WINDOW)-1:0]         old_slot,
  input  mws_pkg::mws_tag_t                     tag_in,
  output logic                                  s2_valid,
  output logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW):0] s2_cs,
  output mws_pkg::mws_tag_t                     s2_tag
);

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int KW       = $clog2(MAX_WINDOW);
  localparam int CS_W     = SAMPLE_BITS + KW + 1;
  localparam int LS_DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int LS_AW    = $clog2(LS_DEPTH);

  logic signed [SAMPLE_BITS-1:0] line_store [LS_DEPTH];
  logic signed [CS_W-1:0]        col_sums [MAX_WIDTH];

  logic [LS_AW-1:0]              wr_addr;
  logic [LS_AW-1:0]              rd_addr;
  logic signed [SAMPLE_BITS-1:0] old_rd;
  logic signed [CS_W-1:0]        sum_rd;
  logic                          fwd_hit;
  logic signed [CS_W-1:0]        fwd_sum;
  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic [CW-1:0]                 s1_col;
  mws_pkg::mws_tag_t             s1_tag;
  logic signed [CS_W-1:0]        prev_sum;
  logic signed [CS_W-1:0]        cs;

  assign wr_addr = LS_AW'(slot * MAX_WIDTH) + LS_AW'(col);
  assign rd_addr = LS_AW'(old_slot * MAX_WIDTH) + LS_AW'(col);

  // A one-sample-wide frame reads a column sum in the same cycle that the
  // previous sample writes it, so that value is bypassed.
  always_comb begin
    if (s1_tag.first_row) begin
      prev_sum = '0;
    end else if (fwd_hit) begin
      prev_sum = fwd_sum;
    end else begin
      prev_sum = sum_rd;
    end
    cs = prev_sum + CS_W'(s1_x) - (s1_tag.sub_row ? CS_W'(old_rd) : CS_W'(0));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (take && tag_in.usable) begin
        line_store[wr_addr] <= sample;
      end
      old_rd  <= line_store[rd_addr];
      sum_rd  <= col_sums[col];
      fwd_hit <= s1_valid && s1_tag.usable && (s1_col == col);
      fwd_sum <= cs;
      s1_x    <= sample;
      s1_col  <= col;
      s1_tag  <= tag_in;
      if (s1_valid && s1_tag.usable) begin
        col_sums[s1_col] <= cs;
      end
      s2_cs  <= cs;
      s2_tag <= s1_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= take;
      s2_valid <= s1_valid;
    end
  end

endmodule

// ----- hw/rtl/mws_hsum.sv -----
module mws_hsum #(
  parameter int DATA_W     = 21,
  parameter int SUM_W      = 25,
  parameter int MAX_WINDOW = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic                              s2_valid,
  input  logic signed [DATA_W-1:0]          s2_cs,
  input  mws_pkg::mws_tag_t                 s2_tag,
  input  logic [$clog2(MAX_WINDOW)-1:0]     tap_sel,
  output logic                              s3_valid,
  output logic signed [SUM_W-1:0]           s3_ws,
  output mws_pkg::mws_tag_t                 s3_tag
);

  logic signed [DATA_W-1:0] taps [MAX_WINDOW];
  logic                     shift;
  logic signed [SUM_W-1:0]  ws;
  logic signed [SUM_W-1:0]  ws_next;

  // The chain holds the column sums of the current row, newest in cell 0.
  assign shift = advance && s2_valid && s2_tag.usable && s2_tag.vert_ok;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      mws_cell #(.DATA_W(DATA_W)) u_cell (
        .clk   (clk),
        .shift (shift),
        .d     (s2_cs),
        .q     (taps[i])
      );
    end else begin : g_body
      mws_cell #(.DATA_W(DATA_W)) u_cell (
        .clk   (clk),
        .shift (shift),
        .d     (taps[i-1]),
        .q     (taps[i])
      );
    end
  end

  assign ws_next = (s2_tag.first_col ? SUM_W'(0) : ws) + SUM_W'(s2_cs)
                 - (s2_tag.sub_col ? SUM_W'(taps[tap_sel]) : SUM_W'(0));

  always_ff @(posedge clk) begin
    if (shift) begin
      ws <= ws_next;
    end
    if (advance) begin
      s3_ws  <= ws_next;
      s3_tag <= s2_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

endmodule

// ----- hw/rtl/max_window_sum_2d_unit.sv -----
// Largest k by k window sum over a raster-order frame, one sample per cycle unless in_stall.
// The result of a frame passes s1, s2, s3 and the result register after its last sample.
// Input is held off only while a finished result waits on the output and the
// next result has reached the end of the three-stage pipeline.
// Reset loads width 1024, height 1024, window 3 and restarts the frame; a write to
// any of the three registers restarts it too. The line and column stores need no clearing.
module max_window_sum_2d_unit #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mws_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mws_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mws_pkg::OUT_W-1:0]     max_sum,
  output logic                                 status
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int KW    = $clog2(MAX_WINDOW);
  localparam int KX    = KW + 1;
  localparam int EW    = $clog2(MAX_WIDTH + 1);
  localparam int CS_W  = SAMPLE_BITS + KW + 1;
  localparam int SUM_W = CS_W + KW;
  localparam int EXT_W = (SUM_W > mws_pkg::OUT_W) ? SUM_W : mws_pkg::OUT_W;
  localparam int HW    = mws_pkg::CFG_W;

  logic [mws_pkg::CFG_W-1:0]  frame_width;
  logic [mws_pkg::CFG_W-1:0]  frame_height;
  logic [mws_pkg::K_W-1:0]    window_size;
  logic                       cfg_hit;

  logic [mws_pkg::ROW_W-1:0]  row;
  logic [CW-1:0]              col;
  logic [KW-1:0]              slot;
  logic [KW-1:0]              old_slot;
  logic [KX-1:0]              slot_x;
  logic [KX-1:0]              k_x;

  logic [EW-1:0]              eff_w;
  logic [HW-1:0]              eff_h;
  logic [HW-1:0]              row_x;
  logic [HW-1:0]              k_h;
  logic [EW-1:0]              col_x;
  logic [EW-1:0]              k_w;
  logic                       last_col;
  logic                       last_row;
  logic                       usable;
  mws_pkg::mws_tag_t          tag_in;
  logic [KW-1:0]              tap_sel;

  logic                       advance;
  logic                       take;

  logic                       s2_valid;
  logic signed [CS_W-1:0]     s2_cs;
  mws_pkg::mws_tag_t          s2_tag;
  logic                       s3_valid;
  logic signed [SUM_W-1:0]    s3_ws;
  mws_pkg::mws_tag_t          s3_tag;

  logic signed [SUM_W-1:0]    best;
  logic signed [SUM_W-1:0]    best_now;
  logic signed [EXT_W-1:0]    best_ext;
  logic                       hit;
  logic                       result_ready;

  localparam logic signed [SUM_W-1:0] BEST_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Register file.
  always_comb begin
    unique case (cfg_index)
      mws_pkg::REG_FRAME_WIDTH,
      mws_pkg::REG_FRAME_HEIGHT,
      mws_pkg::REG_WINDOW_SIZE: cfg_hit = cfg_we;
      default:                  cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= mws_pkg::CFG_W'(1024);
      frame_height <= mws_pkg::CFG_W'(1024);
      window_size  <= mws_pkg::K_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mws_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        mws_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        mws_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_data[mws_pkg::K_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size and the position flags of the incoming sample.
  always_comb begin
    if (frame_width == '0) begin
      eff_w = EW'(1);
    end else if (frame_width > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = HW'(1);
    end else if (frame_height > mws_pkg::ROW_LIMIT) begin
      eff_h = HW'(mws_pkg::ROW_LIMIT);
    end else begin
      eff_h = frame_height;
    end

    row_x = HW'(row);
    k_h   = HW'(window_size);
    col_x = EW'(col);
    k_w   = EW'(window_size);

    last_col = (col_x + EW'(1)) >= eff_w;
    last_row = (row_x + HW'(1)) >= eff_h;
    usable   = (window_size != '0) && (window_size <= MAX_WINDOW)
            && (k_w <= eff_w) && (k_h <= eff_h);

    tag_in.usable    = usable;
    tag_in.first_row = (row == '0);
    tag_in.sub_row   = (row_x >= k_h);
    tag_in.vert_ok   = (row_x + HW'(1)) >= k_h;
    tag_in.first_col = (col == '0);
    tag_in.sub_col   = (col_x >= k_w);
    tag_in.win_ok    = (col_x + EW'(1)) >= k_w;
    tag_in.last      = last_col && last_row;

    // Slot of the row that leaves the window, modulo MAX_WINDOW, the line store's row slots.
    slot_x = KX'(slot);
    k_x    = KX'(window_size);
    if (slot_x >= k_x) begin
      old_slot = KW'(slot_x - k_x);
    end else begin
      old_slot = KW'(slot_x + KX'(MAX_WINDOW) - k_x);
    end

    tap_sel = KW'(window_size - mws_pkg::K_W'(1));
  end

  // The pipeline holds only when a result would overwrite one still waiting.
  assign result_ready = s3_valid && s3_tag.last;
  assign advance      = !(result_ready && out_valid && out_stall);
  assign in_stall     = !advance;
  assign take         = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      row  <= '0;
      col  <= '0;
      slot <= '0;
    end else if (take) begin
      if (last_col) begin
        col <= '0;
        if (last_row) begin
          row  <= '0;
          slot <= '0;
        end else begin
          row  <= row + mws_pkg::ROW_W'(1);
          slot <= (slot == KW'(MAX_WINDOW - 1)) ? '0 : slot + KW'(1);
        end
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  mws_vsum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_vsum (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .take     (take),
    .sample   (sample),
    .col      (col),
    .slot     (slot),
    .old_slot (old_slot),
    .tag_in   (tag_in),
    .s2_valid (s2_valid),
    .s2_cs    (s2_cs),
    .s2_tag   (s2_tag)
  );

  mws_hsum #(
    .DATA_W     (CS_W),
    .SUM_W      (SUM_W),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_hsum (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .s2_valid (s2_valid),
    .s2_cs    (s2_cs),
    .s2_tag   (s2_tag),
    .tap_sel  (tap_sel),
    .s3_valid (s3_valid),
    .s3_ws    (s3_ws),
    .s3_tag   (s3_tag)
  );

  // Running maximum and the result register.
  assign hit      = s3_valid && s3_tag.usable && s3_tag.vert_ok && s3_tag.win_ok
                 && (s3_ws > best);
  assign best_now = hit ? s3_ws : best;
  assign best_ext = EXT_W'(best_now);

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      best <= BEST_MIN;
    end else if (advance && s3_valid) begin
      best <= s3_tag.last ? BEST_MIN : best_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result_ready) begin
      max_sum <= s3_tag.usable ? best_ext[mws_pkg::OUT_W-1:0] : '0;
      status  <= !s3_tag.usable;
    end
  end

endmodule
